@@ design/cau_pkg.sv @@
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

	localparam int CAU_FRAC_BITS = 16;
	localparam int CAU_QUO_BITS  = 32;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_MUL   = 3'd2;
	localparam logic [2:0] OP_MAG   = 3'd3;
	localparam logic [2:0] OP_SCALE = 3'd4;
	localparam logic [2:0] OP_DIV   = 3'd5;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] a_real;
		logic signed [31:0] a_imag;
		logic signed [31:0] b_real;
		logic signed [31:0] b_imag;
		logic signed [31:0] scale_factor;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] result_real;
		logic signed [31:0] result_imag;
		logic [1:0]         status;
	} res_t;

	typedef struct packed {
		logic        neg;
		logic        ovf;
		logic [64:0] rem;
		logic [31:0] lo;
		logic [31:0] quo;
	} div_lane_t;

	typedef struct packed {
		logic        is_div;
		logic        dz;
		logic        sat;
		logic [31:0] re;
		logic [31:0] im;
		logic [63:0] den;
		div_lane_t   lr;
		div_lane_t   li;
	} div_word_t;

endpackage

@@ design/cau_front.sv @@
// Product, combine, saturate and divide-setup stages ahead of the divider chain.
module cau_front import cau_pkg::*; #(
	parameter int FRAC_BITS = CAU_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  cmd_t      in_word,
	output logic      out_valid,
	output div_word_t out_word
);

	localparam int MW = 64 + FRAC_BITS;

	function automatic logic [32:0] sat32(input logic signed [64:0] v);
		logic signed [64:0] maxv;
		logic signed [64:0] minv;
		maxv = 65'sd2147483647;
		minv = -65'sd2147483648;
		if (v > maxv) return {1'b1, 32'h7FFF_FFFF};
		else if (v < minv) return {1'b1, 32'h8000_0000};
		return {1'b0, v[31:0]};
	endfunction

	logic signed [31:0] y0, y1;
	logic signed [63:0] p0, p1, p2, p3, p4, p5;
	logic signed [32:0] as_re, as_im;

	logic               v_s1;
	logic [2:0]         op_s1;
	logic signed [63:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic signed [32:0] as_re_s1, as_im_s1;

	logic               v_s2;
	logic [2:0]         op_s2;
	logic signed [64:0] re_s2, im_s2;
	logic [63:0]        den_s2;

	logic               v_s3;
	logic               div_s3, dz_s3, sat_s3, neg_re_s3, neg_im_s3;
	logic [31:0]        re_s3, im_s3;
	logic [63:0]        den_s3, mag_re_s3, mag_im_s3;

	logic signed [64:0] re_c, im_c;
	logic signed [64:0] sh_re, sh_im, nr, ni;
	logic [32:0]        sr, si;
	logic [MW-1:0]      m_re, m_im;

	assign y0 = (in_word.opcode == OP_MAG) ? in_word.a_real :
		(in_word.opcode == OP_SCALE) ? in_word.scale_factor : in_word.b_real;
	assign y1 = (in_word.opcode == OP_MAG) ? in_word.a_imag :
		(in_word.opcode == OP_SCALE) ? in_word.scale_factor : in_word.b_imag;
	assign p0 = in_word.a_real * y0;
	assign p1 = in_word.a_imag * y1;
	assign p2 = in_word.a_real * in_word.b_imag;
	assign p3 = in_word.a_imag * in_word.b_real;
	assign p4 = in_word.b_real * in_word.b_real;
	assign p5 = in_word.b_imag * in_word.b_imag;
	assign as_re = (in_word.opcode == OP_SUB) ? in_word.a_real - in_word.b_real :
		in_word.a_real + in_word.b_real;
	assign as_im = (in_word.opcode == OP_SUB) ? in_word.a_imag - in_word.b_imag :
		in_word.a_imag + in_word.b_imag;

	always_comb begin
		re_c = '0;
		im_c = '0;
		unique case (op_s1)
			OP_ADD, OP_SUB: begin
				re_c = 65'(as_re_s1);
				im_c = 65'(as_im_s1);
			end
			OP_MUL: begin
				re_c = 65'(p0_s1) - 65'(p1_s1);
				im_c = 65'(p2_s1) + 65'(p3_s1);
			end
			OP_MAG: re_c = 65'(p0_s1) + 65'(p1_s1);
			OP_SCALE: begin
				re_c = 65'(p0_s1);
				im_c = 65'(p1_s1);
			end
			OP_DIV: begin
				re_c = 65'(p0_s1) + 65'(p1_s1);
				im_c = 65'(p3_s1) - 65'(p2_s1);
			end
			default: ;
		endcase
	end

	assign sh_re = (op_s2 == OP_MUL || op_s2 == OP_MAG || op_s2 == OP_SCALE) ?
		(re_s2 >>> FRAC_BITS) : re_s2;
	assign sh_im = (op_s2 == OP_MUL || op_s2 == OP_MAG || op_s2 == OP_SCALE) ?
		(im_s2 >>> FRAC_BITS) : im_s2;
	assign sr = sat32(sh_re);
	assign si = sat32(sh_im);
	assign nr = -re_s2;
	assign ni = -im_s2;

	assign m_re = {mag_re_s3, {FRAC_BITS{1'b0}}};
	assign m_im = {mag_im_s3, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= in_word.opcode;
			p0_s1 <= p0;
			p1_s1 <= p1;
			p2_s1 <= p2;
			p3_s1 <= p3;
			p4_s1 <= p4;
			p5_s1 <= p5;
			as_re_s1 <= as_re;
			as_im_s1 <= as_im;

			op_s2 <= op_s1;
			re_s2 <= re_c;
			im_s2 <= im_c;
			den_s2 <= $unsigned(p4_s1) + $unsigned(p5_s1);

			div_s3 <= (op_s2 == OP_DIV);
			dz_s3 <= (den_s2 == '0);
			sat_s3 <= sr[32] | si[32];
			re_s3 <= sr[31:0];
			im_s3 <= si[31:0];
			den_s3 <= den_s2;
			neg_re_s3 <= re_s2[64];
			neg_im_s3 <= im_s2[64];
			mag_re_s3 <= re_s2[64] ? nr[63:0] : re_s2[63:0];
			mag_im_s3 <= im_s2[64] ? ni[63:0] : im_s2[63:0];

			out_word.is_div <= div_s3;
			out_word.dz <= dz_s3;
			out_word.sat <= sat_s3;
			out_word.re <= re_s3;
			out_word.im <= im_s3;
			out_word.den <= den_s3;
			out_word.lr.neg <= neg_re_s3;
			out_word.lr.ovf <= 65'(m_re[MW-1:32]) >= 65'(den_s3);
			out_word.lr.rem <= 65'(m_re[MW-1:32]);
			out_word.lr.lo <= m_re[31:0];
			out_word.lr.quo <= '0;
			out_word.li.neg <= neg_im_s3;
			out_word.li.ovf <= 65'(m_im[MW-1:32]) >= 65'(den_s3);
			out_word.li.rem <= 65'(m_im[MW-1:32]);
			out_word.li.lo <= m_im[31:0];
			out_word.li.quo <= '0;
		end
	end

endmodule

@@ design/cau_cell.sv @@
// One restoring division step for both result parts, registered.
module cau_cell import cau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  div_word_t in_word,
	output logic      out_valid,
	output div_word_t out_word
);

	function automatic div_lane_t step(input div_lane_t l, input logic [63:0] den);
		div_lane_t   o;
		logic [64:0] r2;
		logic        qb;
		o = l;
		r2 = {l.rem[63:0], l.lo[31]};
		qb = (r2 >= {1'b0, den});
		o.rem = qb ? r2 - {1'b0, den} : r2;
		o.lo = {l.lo[30:0], 1'b0};
		o.quo = {l.quo[30:0], qb};
		return o;
	endfunction

	div_word_t nxt;

	always_comb begin
		nxt = in_word;
		nxt.lr = step(in_word.lr, in_word.den);
		nxt.li = step(in_word.li, in_word.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) out_word <= nxt;
	end

endmodule

@@ design/complex_arithmetic_unit.sv @@
// Top level of the complex arithmetic unit: input skid, front stages, divider chain, output.
//
// Commands arrive on the cmd channel (cmd_valid/cmd_stall, word cmd of type cmd_t) and
// results leave on the res channel (res_valid/res_stall, word res of type res_t).
// A word moves when valid is high and stall is low at a rising clock edge.
// Operations: add, subtract, multiply, squared magnitude, real scale and divide on
// signed fixed-point complex values with FRAC_BITS fraction bits.
// Every command produces exactly one result, in order.
// Every opcode takes the same path: four front stages (products, combine,
// saturate/negate, divide setup), 32 divider cells that each resolve one quotient
// bit, and the output register. Throughput is one word per cycle when not stalled.
// When res_stall holds a waiting result, the whole pipeline freezes; one more
// command is still taken into the input skid register, after which cmd_stall rises.
// Reset clears all valid flags and the skid; no result is pending afterwards.
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int FRAC_BITS = CAU_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	function automatic logic [32:0] finish(input div_lane_t l);
		logic [31:0] lim;
		logic [31:0] q;
		logic        s;
		lim = l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		s = l.ovf || (l.quo > lim);
		q = s ? lim : l.quo;
		return {s, l.neg ? 32'(-q) : q};
	endfunction

	logic      en;
	logic      skid_full_q;
	cmd_t      skid_q;
	logic      acc;
	logic      pipe_valid;
	cmd_t      pipe_word;

	logic      chain_v [CAU_QUO_BITS+1];
	div_word_t chain_w [CAU_QUO_BITS+1];

	div_word_t last;
	logic [32:0] fr, fi;

	assign en = !(res_valid && res_stall);
	assign cmd_stall = skid_full_q;
	assign acc = cmd_valid && !skid_full_q;
	assign pipe_valid = skid_full_q || cmd_valid;
	assign pipe_word = skid_full_q ? skid_q : cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) skid_full_q <= 1'b0;
		else if (en) skid_full_q <= 1'b0;
		else if (acc) skid_full_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (!en && acc) skid_q <= cmd;
	end

	cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pipe_valid),
		.in_word  (pipe_word),
		.out_valid(chain_v[0]),
		.out_word (chain_w[0])
	);

	for (genvar g = 0; g < CAU_QUO_BITS; g++) begin : g_cell
		cau_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (chain_v[g]),
			.in_word  (chain_w[g]),
			.out_valid(chain_v[g+1]),
			.out_word (chain_w[g+1])
		);
	end

	assign last = chain_w[CAU_QUO_BITS];
	assign fr = finish(last.lr);
	assign fi = finish(last.li);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else if (en) res_valid <= chain_v[CAU_QUO_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (last.is_div) begin
				if (last.dz) begin
					res.result_real <= '0;
					res.result_imag <= '0;
					res.status <= ST_DZ;
				end else begin
					res.result_real <= fr[31:0];
					res.result_imag <= fi[31:0];
					res.status <= (fr[32] || fi[32]) ? ST_SAT : ST_OK;
				end
			end else begin
				res.result_real <= last.re;
				res.result_imag <= last.im;
				res.status <= last.sat ? ST_SAT : ST_OK;
			end
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the complex arithmetic unit: queued stimulus, random idling, in-order result check.
module tb_top;
	import cau_pkg::*;

	localparam logic [2:0] OP_RSVD_LO = 3'd6;
	localparam logic [2:0] OP_RSVD_HI = 3'd7;
	localparam int LATENCY = 37;
	localparam int STALL_LIMIT = 4000;
	localparam int CALM_FROM = 300;
	localparam int CALM_TO = 600;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	cmd_t pending_cmds[$];
	res_t expected_res[$];
	int cycle_cnt;
	int quiet_cycles;
	int errors;
	bit stim_done;
	bit cmd_taken;

	complex_arithmetic_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] clamp32(logic signed [127:0] v, inout bit sat);
		if (v > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic res_t complex_result(cmd_t c);
		logic signed [127:0] ar, ai, br, bi, sf, den, nr, ni;
		bit sat;
		res_t r;
		ar = c.a_real;
		ai = c.a_imag;
		br = c.b_real;
		bi = c.b_imag;
		sf = c.scale_factor;
		sat = 1'b0;
		r.result_real = '0;
		r.result_imag = '0;
		r.status = ST_OK;
		case (c.opcode)
			OP_ADD: begin
				r.result_real = clamp32(ar + br, sat);
				r.result_imag = clamp32(ai + bi, sat);
			end
			OP_SUB: begin
				r.result_real = clamp32(ar - br, sat);
				r.result_imag = clamp32(ai - bi, sat);
			end
			OP_MUL: begin
				r.result_real = clamp32((ar * br - ai * bi) >>> CAU_FRAC_BITS, sat);
				r.result_imag = clamp32((ar * bi + ai * br) >>> CAU_FRAC_BITS, sat);
			end
			OP_MAG: r.result_real = clamp32((ar * ar + ai * ai) >>> CAU_FRAC_BITS, sat);
			OP_SCALE: begin
				r.result_real = clamp32((ar * sf) >>> CAU_FRAC_BITS, sat);
				r.result_imag = clamp32((ai * sf) >>> CAU_FRAC_BITS, sat);
			end
			OP_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.status = ST_DZ;
				end else begin
					nr = (ar * br + ai * bi) <<< CAU_FRAC_BITS;
					ni = (ai * br - ar * bi) <<< CAU_FRAC_BITS;
					r.result_real = clamp32(nr / den, sat);
					r.result_imag = clamp32(ni / den, sat);
				end
			end
			default: ;
		endcase
		if (sat && r.status == ST_OK)
			r.status = ST_SAT;
		return r;
	endfunction

	function automatic cmd_t make_cmd(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
			logic [31:0] br, logic [31:0] bi, logic [31:0] sf);
		cmd_t c;
		c.opcode = op;
		c.a_real = ar;
		c.a_imag = ai;
		c.b_real = br;
		c.b_imag = bi;
		c.scale_factor = sf;
		return c;
	endfunction

	function automatic logic [31:0] rand_operand();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 2) == 0 ? 32'h8000_0000 :
				($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0);
			1, 2: v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
			3: v = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// stimulus
	initial begin
		logic [2:0] op;
		pending_cmds.push_back(make_cmd(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 0));
		pending_cmds.push_back(make_cmd(OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h3, 32'h4, 0));
		pending_cmds.push_back(make_cmd(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 0));
		pending_cmds.push_back(make_cmd(OP_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
		pending_cmds.push_back(make_cmd(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000,
			32'h0000_8000, 0));
		pending_cmds.push_back(make_cmd(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 0));
		pending_cmds.push_back(make_cmd(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0, 0));
		pending_cmds.push_back(make_cmd(OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'h5, 32'h6, 0));
		pending_cmds.push_back(make_cmd(OP_MAG, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_MAG, 32'h0, 32'h0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
			32'h0001_0000));
		pending_cmds.push_back(make_cmd(OP_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
			32'h8000_0000));
		pending_cmds.push_back(make_cmd(OP_SCALE, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0,
			32'h0000_0001));
		pending_cmds.push_back(make_cmd(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 0));
		pending_cmds.push_back(make_cmd(OP_DIV, 32'h0006_0000, 32'hFFFC_0000, 32'h0001_0000,
			32'h0001_0000, 0));
		pending_cmds.push_back(make_cmd(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 0));
		pending_cmds.push_back(make_cmd(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 0));
		pending_cmds.push_back(make_cmd(OP_DIV, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 0));
		pending_cmds.push_back(make_cmd(OP_DIV, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0, 0));
		pending_cmds.push_back(make_cmd(OP_RSVD_LO, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3, 32'h4));
		pending_cmds.push_back(make_cmd(OP_RSVD_HI, 32'h8000_0000, 32'h1, 32'h2, 32'h3, 32'h4));
		repeat (600) begin
			op = 3'($urandom_range(0, 15) == 0 ? $urandom_range(OP_RSVD_LO, OP_RSVD_HI)
				: $urandom_range(OP_ADD, OP_DIV));
			pending_cmds.push_back(make_cmd(op, rand_operand(), rand_operand(),
				rand_operand(), rand_operand(), rand_operand()));
		end
		stim_done = 1'b1;
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_stall = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!cmd_valid || cmd_taken) begin
				if (pending_cmds.size() > 0 && (cycle_cnt inside {[CALM_FROM:CALM_TO]} ||
						$urandom_range(0, 99) >= 25)) begin
					cmd_valid <= 1'b1;
					cmd <= pending_cmds.pop_front();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
			res_stall <= !(cycle_cnt inside {[CALM_FROM:CALM_TO]}) && $urandom_range(0, 99) < 25;
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t want;
		cmd_taken = 1'b0;
		if (arst_n) begin
			cycle_cnt++;
			quiet_cycles++;
			if (cmd_valid && !cmd_stall) begin
				expected_res.push_back(complex_result(cmd));
				cmd_taken = 1'b1;
				quiet_cycles = 0;
			end
			if (res_valid && !res_stall) begin
				quiet_cycles = 0;
				if (expected_res.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word %h", $time, res);
				end else begin
					want = expected_res.pop_front();
					if (res.result_real !== want.result_real) begin
						errors++;
						$display("%0t: result_real expected %h actual %h", $time,
							want.result_real, res.result_real);
					end
					if (res.result_imag !== want.result_imag) begin
						errors++;
						$display("%0t: result_imag expected %h actual %h", $time,
							want.result_imag, res.result_imag);
					end
					if (res.status !== want.status) begin
						errors++;
						$display("%0t: status expected %h actual %h", $time,
							want.status, res.status);
					end
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		wait (stim_done);
		@(posedge clk);
		while (pending_cmds.size() > 0 || cmd_valid || expected_res.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_res.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
